[sv/rds_pkg.sv]
// shared types and constants for the escape run-length and delta decoder
`default_nettype none
package rds_pkg;

  localparam logic [7:0]  RunEscape = 8'hA5;
  localparam logic [7:0]  LitEscape = 8'h5A;
  localparam logic [15:0] LitPair   = {LitEscape, LitEscape};
  localparam int          ByteBits  = 8;

  // floor(n / 3) for n below 512 as (n * 171) >> 9
  localparam logic [7:0]  ThirdMul   = 8'd171;
  localparam int          ThirdShift = 9;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_COUNT,
    RUN_VALUE
  } run_phase_t;

  typedef enum logic [1:0] {
    LIT_NONE,
    LIT_LOW,
    LIT_HIGH
  } lit_phase_t;

  // everything one compressed byte produces, at most three descriptor words
  typedef struct packed {
    logic              lit_vld;
    logic [15:0]       lit_sample;
    logic              run_vld;
    logic [15:0]       run_start;
    logic signed [7:0] run_step;
    logic [8:0]        run_count;
    logic              stat_vld;
    logic              stat_trunc;
  } bundle_t;

endpackage
`default_nettype wire

[sv/rds_ifs.sv]
// valid/ready channels for compressed bytes and run descriptors
`default_nettype none
interface rds_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface rds_desc_if;
  logic              valid;
  logic              ready;
  logic [15:0]       start_sample;
  logic signed [7:0] step_value;
  logic [8:0]        sample_count;
  logic              truncated;
  logic              last_of_item;

  modport source (output valid, output start_sample, output step_value,
                  output sample_count, output truncated, output last_of_item,
                  input ready);
  modport sink   (input valid, input start_sample, input step_value,
                  input sample_count, input truncated, input last_of_item,
                  output ready);
endinterface
`default_nettype wire

[sv/rds_front.sv]
// front end: byte intake, run-length and delta decode into a result bundle
`default_nettype none
module rds_front (
  input  wire logic        clk,
  input  wire logic        rst,
  rds_byte_if.sink         comp,
  input  wire logic        q_full,
  output logic             push,
  output rds_pkg::bundle_t bundle
);

  rds_pkg::run_phase_t run_phase, run_phase_next;
  logic [7:0]          run_repeat, run_repeat_next;
  rds_pkg::lit_phase_t lit_phase, lit_phase_next;
  logic [7:0]          literal_low, literal_low_next;
  logic [15:0]         previous_sample, previous_sample_next;

  logic                accept;
  logic                feed;
  logic [7:0]          v;
  logic [8:0]          n0, n1, n2;
  rds_pkg::lit_phase_t lp1, lp2, lp3;
  logic [7:0]          ll1, ll3;
  logic [15:0]         prev2, prev3;
  logic [15:0]         lit_sample;
  logic                lit_hit;
  logic                run_hit;
  logic [15:0]         run_start;
  logic signed [7:0]   run_step;
  logic [8:0]          run_count;
  logic [16:0]         third_prod;
  logic [6:0]          lits;
  logic [8:0]          three_lits;
  logic [8:0]          rem9;
  logic [1:0]          rem;
  logic signed [17:0]  delta_prod;
  logic [15:0]         delta_ext;
  logic                trunc;

  assign comp.ready = !q_full;
  assign accept     = comp.valid && comp.ready;
  assign v          = comp.data_byte;

  // run-length escape
  always_comb begin
    feed            = 1'b0;
    n0              = 9'd1;
    run_phase_next  = run_phase;
    run_repeat_next = run_repeat;
    case (run_phase)
      rds_pkg::RUN_COUNT: begin
        run_repeat_next = v;
        run_phase_next  = rds_pkg::RUN_VALUE;
      end
      rds_pkg::RUN_VALUE: begin
        feed            = 1'b1;
        n0              = {1'b0, run_repeat} + 9'd1;
        run_phase_next  = rds_pkg::RUN_IDLE;
        run_repeat_next = '0;
      end
      default: begin
        if (v == rds_pkg::RunEscape) begin
          run_phase_next = rds_pkg::RUN_COUNT;
        end else begin
          feed = 1'b1;
        end
      end
    endcase
  end

  // finish a pending literal with the first expanded bytes
  always_comb begin
    lp1 = lit_phase;
    ll1 = literal_low;
    n1  = n0;
    if (lit_phase == rds_pkg::LIT_LOW) begin
      ll1 = v;
      lp1 = rds_pkg::LIT_HIGH;
      n1  = n0 - 9'd1;
    end
    lp2        = lp1;
    prev2      = previous_sample;
    n2         = n1;
    lit_sample = {v, ll1};
    lit_hit    = 1'b0;
    if (lp1 == rds_pkg::LIT_HIGH && n1 != 9'd0) begin
      lit_hit = 1'b1;
      lp2     = rds_pkg::LIT_NONE;
      n2      = n1 - 9'd1;
      prev2   = lit_sample;
    end
  end

  // rest of the run: literal pairs or one delta descriptor
  assign third_prod = n2 * rds_pkg::ThirdMul;
  assign lits       = third_prod[rds_pkg::ThirdShift +: 7];
  assign three_lits = {1'b0, lits, 1'b0} + {2'b00, lits};
  assign rem9       = n2 - three_lits;
  assign rem        = rem9[1:0];
  assign delta_ext  = {{rds_pkg::ByteBits{v[7]}}, v};
  assign delta_prod = $signed({1'b0, n2}) * $signed(v);

  always_comb begin
    run_hit   = 1'b0;
    run_start = prev2 + delta_ext;
    run_step  = $signed(v);
    run_count = n2;
    lp3       = lp2;
    ll3       = ll1;
    prev3     = prev2;
    if (n2 != 9'd0) begin
      if (v == rds_pkg::LitEscape) begin
        run_start = rds_pkg::LitPair;
        run_step  = '0;
        run_count = {2'b00, lits};
        if (lits != 7'd0) begin
          run_hit = 1'b1;
          prev3   = rds_pkg::LitPair;
        end
        if (rem == 2'd1) begin
          lp3 = rds_pkg::LIT_LOW;
        end else if (rem == 2'd2) begin
          lp3 = rds_pkg::LIT_HIGH;
          ll3 = rds_pkg::LitEscape;
        end
      end else begin
        run_hit = 1'b1;
        prev3   = prev2 + delta_prod[15:0];
      end
    end
  end

  always_comb begin
    lit_phase_next       = feed ? lp3 : lit_phase;
    literal_low_next     = feed ? ll3 : literal_low;
    previous_sample_next = feed ? prev3 : previous_sample;
    trunc = (run_phase_next != rds_pkg::RUN_IDLE) || (lit_phase_next != rds_pkg::LIT_NONE);

    bundle.lit_vld    = feed && lit_hit;
    bundle.lit_sample = lit_sample;
    bundle.run_vld    = feed && run_hit;
    bundle.run_start  = run_start;
    bundle.run_step   = run_step;
    bundle.run_count  = run_count;
    bundle.stat_vld   = comp.stream_end;
    bundle.stat_trunc = trunc;
    push = accept && (bundle.lit_vld || bundle.run_vld || bundle.stat_vld);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && comp.stream_end)) begin
      run_phase       <= rds_pkg::RUN_IDLE;
      run_repeat      <= '0;
      lit_phase       <= rds_pkg::LIT_NONE;
      literal_low     <= '0;
      previous_sample <= '0;
    end else if (accept) begin
      run_phase       <= run_phase_next;
      run_repeat      <= run_repeat_next;
      lit_phase       <= lit_phase_next;
      literal_low     <= literal_low_next;
      previous_sample <= previous_sample_next;
    end
  end

endmodule
`default_nettype wire

[sv/rds_queue.sv]
// short queue of result bundles between front and back
`default_nettype none
module rds_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rds_pkg::bundle_t  wdata,
  output logic                   full,
  input  wire logic              pop,
  output rds_pkg::bundle_t       rdata,
  output logic                   empty
);

  rds_pkg::bundle_t               store [rds_pkg::QueueDepth];
  logic [rds_pkg::QueuePtrW-1:0]  wr_ptr;
  logic [rds_pkg::QueuePtrW-1:0]  rd_ptr;
  logic [rds_pkg::QueuePtrW:0]    fill;

  assign full  = (fill == (rds_pkg::QueuePtrW + 1)'(rds_pkg::QueueDepth));
  assign empty = (fill == '0);
  assign rdata = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/rds_back.sv]
// back end: unpacks bundles into descriptor words behind an output register
`default_nettype none
module rds_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire rds_pkg::bundle_t q_rdata,
  output logic                  q_pop,
  rds_desc_if.source            desc
);

  rds_pkg::bundle_t  cur;
  logic [2:0]        pend;
  logic [2:0]        sel;
  logic [2:0]        pend_left;
  logic [2:0]        pend_next;
  logic              load;
  logic              fire;
  logic              out_valid;
  logic [15:0]       out_start;
  logic signed [7:0] out_step;
  logic [8:0]        out_count;
  logic              out_trunc;
  logic              out_last;
  logic [15:0]       w_start;
  logic signed [7:0] w_step;
  logic [8:0]        w_count;
  logic              w_trunc;

  // pending order: literal, run, status
  always_comb begin
    sel     = 3'b000;
    w_start = '0;
    w_step  = '0;
    w_count = '0;
    w_trunc = 1'b0;
    if (pend[0]) begin
      sel     = 3'b001;
      w_start = cur.lit_sample;
      w_count = 9'd1;
    end else if (pend[1]) begin
      sel     = 3'b010;
      w_start = cur.run_start;
      w_step  = cur.run_step;
      w_count = cur.run_count;
    end else if (pend[2]) begin
      sel     = 3'b100;
      w_trunc = cur.stat_trunc;
    end
    load      = !out_valid || desc.ready;
    fire      = load && (pend != 3'b000);
    pend_left = pend & ~sel;
    pend_next = fire ? pend_left : pend;
    q_pop     = (pend_next == 3'b000) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        pend <= {q_rdata.stat_vld, q_rdata.run_vld, q_rdata.lit_vld};
      end else begin
        pend <= pend_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (load) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
    if (fire) begin
      out_start <= w_start;
      out_step  <= w_step;
      out_count <= w_count;
      out_trunc <= w_trunc;
      out_last  <= (pend_left == 3'b000);
    end
  end

  assign desc.valid        = out_valid;
  assign desc.start_sample = out_start;
  assign desc.step_value   = out_step;
  assign desc.sample_count = out_count;
  assign desc.truncated    = out_trunc;
  assign desc.last_of_item = out_last;

endmodule
`default_nettype wire

[sv/rle_delta_sample_decoder.sv]
// top level of the escape run-length and delta decoder for 16-bit samples
`default_nettype none
// takes one compressed byte per word on comp and gives run descriptors on desc:
// (start_sample, step_value, sample_count) stands for start, start+step, ... mod 2^16,
// with literal samples sent as step 0. the front end decodes a whole byte combinationally
// (escape state, pending literal and last sample, with 9x8 multiplies for the run end
// value and the literal pair count) and writes at most one bundle of up to three
// descriptors into a four-entry queue; the back end unpacks bundles into words through
// an output register. bytes are taken at one per clock while the queue has room, and
// descriptors leave at one per clock while desc is ready. a descriptor passes the queue,
// the current bundle register and the output register before it is offered. the word
// with sample_count 0 is the end-of-stream status, with truncated set if the stream
// stopped inside an escape; after it all decode state is back at its reset value
module rle_delta_sample_decoder (
  input  wire logic  clk,
  input  wire logic  rst,
  rds_byte_if.sink   comp,
  rds_desc_if.source desc
);

  // bundle handoff between front and back
  rds_pkg::bundle_t q_wdata;
  rds_pkg::bundle_t q_rdata;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;

  // byte intake and decode
  rds_front u_front (
    .clk    (clk),
    .rst    (rst),
    .comp   (comp),
    .q_full (q_full),
    .push   (q_push),
    .bundle (q_wdata)
  );

  // decouples intake from the descriptor port
  rds_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // one descriptor word per clock while desc is ready
  rds_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .desc    (desc)
  );

  // a bundle is never written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("bundle written into full queue");

  // a status word closes its byte and carries no samples
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (desc.valid && desc.sample_count == 9'd0) |->
      (desc.last_of_item && desc.start_sample == 16'd0 && desc.step_value == 8'sd0))
    else $error("malformed status word");

  // truncation is only reported on a status word
  a_trunc_status: assert property (@(posedge clk) disable iff (rst)
    (desc.valid && desc.truncated) |-> desc.sample_count == 9'd0)
    else $error("truncation on a sample descriptor");

  // nothing leaves the back end without a bundle having been queued
  a_pop_source: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
